// ----- src/taf_pkg.sv -----
// Package for the tangent arc fillet: pipeline context type, stage map and sine table.
`timescale 1ns / 1ps
package taf_pkg;

  localparam int N_STAGES   = 139;
  localparam int ST_SUM     = 2;
  localparam int ST_SQ      = 3;
  localparam int ST_LEN     = 4;
  localparam int ST_SQRT1   = 5;
  localparam int ST_NDIV    = 21;
  localparam int ST_DIV1    = 22;
  localparam int ST_NORM    = 52;
  localparam int ST_DOTP    = 53;
  localparam int ST_DOT     = 54;
  localparam int ST_CH      = 55;
  localparam int ST_CHSQ    = 56;
  localparam int ST_SARG    = 57;
  localparam int ST_SQRT2   = 58;
  localparam int ST_SH      = 74;
  localparam int ST_DIV2    = 75;
  localparam int ST_TH      = 105;
  localparam int ST_DIV3    = 106;
  localparam int ST_TD      = 136;
  localparam int ST_MUL     = 137;
  localparam int ST_RND     = 138;
  localparam int ST_OUT     = 139;
  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 30;

  localparam logic [13:0] RADIUS_RESET = 14'd2048;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef logic [14:0] qsin_t [0:90];

  typedef struct packed {
    logic signed [23:0]       kx;
    logic signed [23:0]       ky;
    logic [13:0]              r;
    logic signed [15:0]       c1;
    logic signed [15:0]       s1;
    logic signed [15:0]       c2;
    logic signed [15:0]       s2;
    logic signed [16:0]       bx;
    logic signed [16:0]       by;
    logic [30:0]              sqx;
    logic [30:0]              sqy;
    logic [30:0]              sarg;
    logic [15:0]              root;
    logic                     opp;
    logic                     neg_x;
    logic                     neg_y;
    logic [29:0]              num_a;
    logic [29:0]              den_a;
    logic [30:0]              rem_a;
    logic [29:0]              quo_a;
    logic [29:0]              num_b;
    logic [29:0]              den_b;
    logic [30:0]              rem_b;
    logic [29:0]              quo_b;
    logic signed [15:0]       nx;
    logic signed [15:0]       ny;
    logic signed [15:0]       ch;
    logic                     tzero;
    logic [28:0]              cdist;
    logic [28:0]              tdist;
    logic [5:0][45:0]         pr;
    logic [5:0][23:0]         o;
    logic                     sat;
  } ctx_t;

  function automatic longint unsigned taylor_step(longint unsigned t, longint unsigned x);
    longint unsigned u;
    u = (t * x) >> 30;
    return (u * x) >> 30;
  endfunction

  function automatic logic [14:0] quarter_sine(int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x = longint'(k) * 64'd18740330;
    sum = longint'(x);
    term = taylor_step(x, x) / 64'd6;
    sum = sum - longint'(term);
    term = taylor_step(term, x) / 64'd20;
    sum = sum + longint'(term);
    term = taylor_step(term, x) / 64'd42;
    sum = sum - longint'(term);
    term = taylor_step(term, x) / 64'd72;
    sum = sum + longint'(term);
    term = taylor_step(term, x) / 64'd110;
    sum = sum - longint'(term);
    term = taylor_step(term, x) / 64'd156;
    sum = sum + longint'(term);
    term = taylor_step(term, x) / 64'd210;
    sum = sum - longint'(term);
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >>> 16;
    if (sum > 16384) sum = 16384;
    return 15'(sum);
  endfunction

  function automatic qsin_t build_qsin();
    qsin_t t;
    for (int k = 0; k <= 90; k++) t[k] = quarter_sine(k);
    return t;
  endfunction

  localparam qsin_t QSIN = build_qsin();

  function automatic logic signed [15:0] sin_deg(logic [8:0] d);
    logic signed [15:0] v;
    if (d < 9'd90) v = $signed({1'b0, QSIN[7'(d)]});
    else if (d < 9'd180) v = $signed({1'b0, QSIN[7'(9'd180 - d)]});
    else if (d < 9'd270) v = -$signed({1'b0, QSIN[7'(d - 9'd180)]});
    else v = -$signed({1'b0, QSIN[7'(9'd360 - d)]});
    return v;
  endfunction

  function automatic logic [8:0] wrap360(logic [9:0] d);
    logic [9:0] w;
    w = (d >= 10'd360) ? d - 10'd360 : d;
    return w[8:0];
  endfunction

  function automatic logic signed [32:0] rnd14(logic signed [45:0] v);
    logic [46:0] mag;
    logic [46:0] m;
    mag = v[45] ? (~{v[45], v} + 47'd1) : {v[45], v};
    m = (mag + 47'd8192) >> 14;
    return v[45] ? -$signed(33'(m)) : $signed(33'(m));
  endfunction

endpackage

// ----- src/tangent_arc_fillet.sv -----
// Tangent arc fillet: fully pipelined corner geometry engine.
// An accepted input beat is registered into st[1] and moves stage by stage to st[N_STAGES], the result beat.
// Throughput: one corner per cycle; the whole pipeline holds while a result waits.
// Square roots and divisions run one result bit per stage.
// Reset clears all valid bits and loads the radius register with 2048.
`timescale 1ns / 1ps
module tangent_arc_fillet
  import taf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // corner_x, corner_y, edge_one_deg, edge_two_deg, zero pad
  input  logic [71:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // centre_x, centre_y, touch_one_x, touch_one_y, touch_two_x, touch_two_y
  output logic [143:0] m_tdata,
  // saturated
  output logic [0:0]   m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [13:0]  cfg_data
);

  logic [13:0] radius;
  ctx_t        st  [1:N_STAGES];
  logic        vld [1:N_STAGES];
  logic        en;
  ctx_t        head;

  function automatic ctx_t step(ctx_t c, int i);
    ctx_t               n;
    logic [15:0]        trial;
    logic [4:0]         pb;
    logic [30:0]        r2;
    logic signed [32:0] v;
    logic signed [33:0] s;
    logic [14:0]        shv;
    logic [29:0]        thv;
    logic [16:0]        ax;
    logic [16:0]        ay;
    n = c;
    if (i == ST_SUM) begin
      n.bx = 17'(c.c1) + 17'(c.c2);
      n.by = 17'(c.s1) + 17'(c.s2);
    end else if (i == ST_SQ) begin
      n.sqx = 31'(c.bx * c.bx);
      n.sqy = 31'(c.by * c.by);
    end else if (i == ST_LEN) begin
      n.sarg = c.sqx + c.sqy;
      n.opp  = (c.sqx + c.sqy) < 31'd4;
      n.root = '0;
    end else if ((i >= ST_SQRT1 && i < ST_SQRT1 + SQRT_STEPS) ||
                 (i >= ST_SQRT2 && i < ST_SQRT2 + SQRT_STEPS)) begin
      pb = (i >= ST_SQRT2) ? 5'(15 - (i - ST_SQRT2)) : 5'(15 - (i - ST_SQRT1));
      trial = c.root | (16'd1 << pb);
      if (32'(trial) * 32'(trial) <= {1'b0, c.sarg}) n.root = trial;
    end else if (i == ST_NDIV) begin
      ax = c.bx[16] ? 17'(-c.bx) : 17'(c.bx);
      ay = c.by[16] ? 17'(-c.by) : 17'(c.by);
      n.neg_x = c.bx[16];
      n.neg_y = c.by[16];
      n.num_a = (30'(ax) << 14) + 30'(c.root >> 1);
      n.num_b = (30'(ay) << 14) + 30'(c.root >> 1);
      n.den_a = 30'(c.root);
      n.den_b = 30'(c.root);
      n.rem_a = '0;
      n.rem_b = '0;
      n.quo_a = '0;
      n.quo_b = '0;
    end else if ((i >= ST_DIV1 && i < ST_DIV1 + DIV_STEPS) ||
                 (i >= ST_DIV2 && i < ST_DIV2 + DIV_STEPS) ||
                 (i >= ST_DIV3 && i < ST_DIV3 + DIV_STEPS)) begin
      if (i >= ST_DIV3) pb = 5'(29 - (i - ST_DIV3));
      else if (i >= ST_DIV2) pb = 5'(29 - (i - ST_DIV2));
      else pb = 5'(29 - (i - ST_DIV1));
      r2 = {c.rem_a[29:0], c.num_a[pb]};
      if (r2 >= {1'b0, c.den_a}) begin
        n.rem_a = r2 - {1'b0, c.den_a};
        n.quo_a[pb] = 1'b1;
      end else begin
        n.rem_a = r2;
      end
      r2 = {c.rem_b[29:0], c.num_b[pb]};
      if (r2 >= {1'b0, c.den_b}) begin
        n.rem_b = r2 - {1'b0, c.den_b};
        n.quo_b[pb] = 1'b1;
      end else begin
        n.rem_b = r2;
      end
    end else if (i == ST_NORM) begin
      if (c.opp) begin
        n.nx = -c.s1;
        n.ny = c.c1;
      end else begin
        n.nx = c.neg_x ? -$signed(16'(c.quo_a)) : $signed(16'(c.quo_a));
        n.ny = c.neg_y ? -$signed(16'(c.quo_b)) : $signed(16'(c.quo_b));
      end
    end else if (i == ST_DOTP) begin
      n.pr[0] = 46'(c.nx * c.c1);
      n.pr[1] = 46'(c.ny * c.s1);
    end else if (i == ST_DOT) begin
      n.pr[0] = 46'($signed(c.pr[0]) + $signed(c.pr[1]));
    end else if (i == ST_CH) begin
      v = rnd14($signed(c.pr[0]));
      if (v > 33'sd16384) n.ch = ONE_Q14;
      else if (v < -33'sd16384) n.ch = -ONE_Q14;
      else n.ch = 16'(v);
    end else if (i == ST_CHSQ) begin
      n.sarg = 31'(c.ch * c.ch);
    end else if (i == ST_SARG) begin
      n.sarg = (31'd1 << 28) - c.sarg;
      n.root = '0;
    end else if (i == ST_SH) begin
      shv = (c.root < 16'd2) ? 15'd2 : 15'(c.root);
      n.tzero = (c.ch <= 16'sd0);
      n.num_a = 30'(shv) << 14;
      n.den_a = (c.ch > 16'sd0) ? 30'(c.ch) : 30'd1;
      n.num_b = (30'(c.r) << 14) + 30'(shv >> 1);
      n.den_b = 30'(shv);
      n.rem_a = '0;
      n.rem_b = '0;
      n.quo_a = '0;
      n.quo_b = '0;
    end else if (i == ST_TH) begin
      thv = (c.quo_a < 30'd2) ? 30'd2 : c.quo_a;
      n.cdist = 29'(c.quo_b);
      n.num_a = (30'(c.r) << 14) + (thv >> 1);
      n.den_a = thv;
      n.rem_a = '0;
      n.quo_a = '0;
      n.num_b = '0;
      n.den_b = 30'd1;
      n.rem_b = '0;
      n.quo_b = '0;
    end else if (i == ST_TD) begin
      n.tdist = c.tzero ? 29'd0 : 29'(c.quo_a);
    end else if (i == ST_MUL) begin
      n.pr[0] = 46'(c.nx * $signed({1'b0, c.cdist}));
      n.pr[1] = 46'(c.ny * $signed({1'b0, c.cdist}));
      n.pr[2] = 46'(c.c1 * $signed({1'b0, c.tdist}));
      n.pr[3] = 46'(c.s1 * $signed({1'b0, c.tdist}));
      n.pr[4] = 46'(c.c2 * $signed({1'b0, c.tdist}));
      n.pr[5] = 46'(c.s2 * $signed({1'b0, c.tdist}));
    end else if (i == ST_RND) begin
      for (int j = 0; j < 6; j++) n.pr[j] = 46'(rnd14($signed(c.pr[j])));
    end else if (i == ST_OUT) begin
      n.sat = 1'b0;
      for (int j = 0; j < 6; j++) begin
        s = (j % 2 == 0) ? 34'(c.kx) : 34'(c.ky);
        s = s + 34'($signed(c.pr[j][32:0]));
        if (s > 34'sd8388607) begin
          n.o[j] = 24'h7FFFFF;
          n.sat  = 1'b1;
        end else if (s < -34'sd8388608) begin
          n.o[j] = 24'h800000;
          n.sat  = 1'b1;
        end else begin
          n.o[j] = 24'(s);
        end
      end
    end
    return n;
  endfunction

  assign en        = !vld[N_STAGES] || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [8:0] e1;
    logic [8:0] e2;
    head    = '0;
    e1      = wrap360({1'b0, s_tdata[56:48]});
    e2      = wrap360({1'b0, s_tdata[65:57]});
    head.kx = $signed(s_tdata[23:0]);
    head.ky = $signed(s_tdata[47:24]);
    head.r  = radius;
    head.s1 = sin_deg(e1);
    head.c1 = sin_deg(wrap360(10'(e1) + 10'd90));
    head.s2 = sin_deg(e2);
    head.c2 = sin_deg(wrap360(10'(e2) + 10'd90));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= N_STAGES; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int i = 2; i <= N_STAGES; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[1] <= head;
      for (int i = 2; i <= N_STAGES; i++) st[i] <= step(st[i-1], i);
    end
  end

  assign m_tvalid   = vld[N_STAGES];
  assign m_tdata    = {st[N_STAGES].o[5], st[N_STAGES].o[4], st[N_STAGES].o[3],
                       st[N_STAGES].o[2], st[N_STAGES].o[1], st[N_STAGES].o[0]};
  assign m_tuser[0] = st[N_STAGES].sat;

endmodule

// ----- src/taf_checker.sv -----
// Port-level checker for the tangent arc fillet, bound to the top level.
`timescale 1ns / 1ps
module taf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata,
  input logic         cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result beat changed while stalled.");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("Input ready does not follow the output stall.");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid after reset.");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("Configuration channel not ready.");

endmodule

bind tangent_arc_fillet taf_checker u_taf_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);
